FILE: hw/rtl/owm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

	// Tick counter width and the width of each timing register
	localparam int COUNT_WIDTH = 10;
	localparam int REG_W       = 10;
	localparam int IDX_W       = 3;
	localparam int CMP_W       = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
	localparam logic [CMP_W-1:0]       CNT_MAX_W = CMP_W'(CNT_MAX);

	// Command opcodes
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_RESET  = 3'd1;
	localparam logic [2:0] OP_WBIT   = 3'd2;
	localparam logic [2:0] OP_WBYTE  = 3'd3;
	localparam logic [2:0] OP_RBIT   = 3'd4;
	localparam logic [2:0] OP_RBYTE  = 3'd5;
	localparam logic [2:0] OP_CLRCRC = 3'd6;

	// Timing register indexes
	localparam logic [IDX_W-1:0] REG_RESET_LOW      = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESENCE_SMPL  = 3'd1;
	localparam logic [IDX_W-1:0] REG_RESET_TAIL     = 3'd2;
	localparam logic [IDX_W-1:0] REG_WRITE0_LOW     = 3'd3;
	localparam logic [IDX_W-1:0] REG_WRITE1_LOW     = 3'd4;
	localparam logic [IDX_W-1:0] REG_WRITE1_TAIL    = 3'd5;
	localparam logic [IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
	localparam logic [IDX_W-1:0] REG_READ_TAIL      = 3'd7;

	typedef struct packed {
		logic [REG_W-1:0] reset_low_us;
		logic [REG_W-1:0] presence_sample_us;
		logic [REG_W-1:0] reset_tail_us;
		logic [REG_W-1:0] write0_low_us;
		logic [REG_W-1:0] write1_low_us;
		logic [REG_W-1:0] write1_tail_us;
		logic [REG_W-1:0] read_sample_us;
		logic [REG_W-1:0] read_tail_us;
	} cfg_t;

	// One result beat
	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] read_data;
		logic [7:0] crc;
	} res_t;

	// Zero low or sample time counts as one tick
	function automatic logic [REG_W-1:0] at_least_one(input logic [REG_W-1:0] d);
		return (d == '0) ? REG_W'(1) : d;
	endfunction

	// Clamp a length to the counter maximum
	function automatic logic [COUNT_WIDTH-1:0] cap_len(input logic [REG_W-1:0] d);
		logic [CMP_W-1:0] w;
		w = CMP_W'(d);
		if (w > CNT_MAX_W) begin
			return CNT_MAX;
		end
		return COUNT_WIDTH'(w);
	endfunction

	// Dallas CRC-8, reflected polynomial 0x8C, one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/one_wire_master_timing_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// 1-Wire bus master driven by one input beat per microsecond tick. Each tick
// beat carries the sampled bus level and an optional command (reset with
// presence detect, write bit/byte, read bit/byte, clear CRC); each produces
// exactly one result beat with the bus drive, busy, done pulse, presence,
// last read data and the running Dallas CRC-8 over bytes read. Commands
// offered while busy are ignored; bytes move LSB first. Slot times come from
// eight 10-bit timing registers written through the cfg port; the user must
// write them between beats, which the block does not enforce. One tick beat
// is taken per clock while in_stall is low; a result passes the input register,
// then a two-entry result buffer; a tick update is one slot sequencer pass.
module one_wire_master_timing_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [owm_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [owm_pkg::REG_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       line_level,
	input  wire logic                       cmd_valid,
	input  wire logic [2:0]                 opcode,
	input  wire logic [7:0]                 write_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            drive_low,
	output logic                            busy_res,
	output logic                            done_res,
	output logic                            presence,
	output logic [7:0]                      read_data,
	output logic [7:0]                      crc_value
);

	owm_pkg::cfg_t cfg;
	owm_pkg::res_t res;
	owm_pkg::res_t out_data;

	logic       valid_s1;
	logic       level_s1;
	logic       cmdv_s1;
	logic [2:0] op_s1;
	logic [7:0] wd_s1;
	logic       room;
	logic       fire;
	logic       accept;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// Input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= line_level;
			cmdv_s1  <= cmd_valid;
			op_s1    <= opcode;
			wd_s1    <= write_data;
		end
	end

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	owm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (fire),
		.line_level (level_s1),
		.cmd_valid  (cmdv_s1),
		.opcode     (op_s1),
		.write_data (wd_s1),
		.cfg        (cfg),
		.res        (res)
	);

	owm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign drive_low = out_data.drive_low;
	assign busy_res  = out_data.busy;
	assign done_res  = out_data.done;
	assign presence  = out_data.presence;
	assign read_data = out_data.read_data;
	assign crc_value = out_data.crc;

endmodule

`default_nettype wire

FILE: hw/rtl/owm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [owm_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [owm_pkg::REG_W-1:0]   cfg_wdata,
	output owm_pkg::cfg_t                    cfg
);

	owm_pkg::cfg_t cfg_q;

	// Timing registers, reset to standard-speed slot values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us       <= owm_pkg::REG_W'(480);
			cfg_q.presence_sample_us <= owm_pkg::REG_W'(70);
			cfg_q.reset_tail_us      <= owm_pkg::REG_W'(410);
			cfg_q.write0_low_us      <= owm_pkg::REG_W'(60);
			cfg_q.write1_low_us      <= owm_pkg::REG_W'(1);
			cfg_q.write1_tail_us     <= owm_pkg::REG_W'(55);
			cfg_q.read_sample_us     <= owm_pkg::REG_W'(15);
			cfg_q.read_tail_us       <= owm_pkg::REG_W'(45);
		end else if (cfg_we) begin
			case (cfg_index)
				owm_pkg::REG_RESET_LOW:     cfg_q.reset_low_us       <= cfg_wdata;
				owm_pkg::REG_PRESENCE_SMPL: cfg_q.presence_sample_us <= cfg_wdata;
				owm_pkg::REG_RESET_TAIL:    cfg_q.reset_tail_us      <= cfg_wdata;
				owm_pkg::REG_WRITE0_LOW:    cfg_q.write0_low_us      <= cfg_wdata;
				owm_pkg::REG_WRITE1_LOW:    cfg_q.write1_low_us      <= cfg_wdata;
				owm_pkg::REG_WRITE1_TAIL:   cfg_q.write1_tail_us     <= cfg_wdata;
				owm_pkg::REG_READ_SAMPLE:   cfg_q.read_sample_us     <= cfg_wdata;
				owm_pkg::REG_READ_TAIL:     cfg_q.read_tail_us       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/owm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step_en,
	input  wire logic           line_level,
	input  wire logic           cmd_valid,
	input  wire logic [2:0]     opcode,
	input  wire logic [7:0]     write_data,
	input  wire owm_pkg::cfg_t  cfg,
	output owm_pkg::res_t       res
);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_TAIL = 4'd3;
	localparam logic [3:0] PH_WR_LOW   = 4'd4;
	localparam logic [3:0] PH_WR_TAIL  = 4'd5;
	localparam logic [3:0] PH_RD_LOW   = 4'd6;
	localparam logic [3:0] PH_RD_WAIT  = 4'd7;
	localparam logic [3:0] PH_RD_TAIL  = 4'd8;

	logic [3:0]                      phase_q, phase_n;
	logic [owm_pkg::COUNT_WIDTH-1:0] tick_q, tick_n, tick_inc, cur_len;
	logic [2:0]                      bit_q, bit_n;
	logic [2:0]                      act_q, act_n;
	logic [7:0]                      shift_q, shift_n;
	logic                            pres_q, pres_n;
	logic [7:0]                      crc_q, crc_n;
	logic [7:0]                      hold_q, hold_n;
	logic                            done_n;
	logic                            wbit;
	logic                            tail_end;
	logic                            fin;
	logic                            rd_family;

	assign wbit      = shift_q[bit_q];
	assign rd_family = (phase_q == PH_RD_LOW) || (phase_q == PH_RD_WAIT) ||
	                   (phase_q == PH_RD_TAIL);
	assign tick_inc  = (tick_q < owm_pkg::CNT_MAX) ? (tick_q + 1'b1) : tick_q;

	// Length of the phase now running
	always_comb begin
		case (phase_q)
			PH_RST_LOW:  cur_len = owm_pkg::cap_len(owm_pkg::at_least_one(cfg.reset_low_us));
			PH_RST_WAIT: cur_len = owm_pkg::cap_len(
			                 owm_pkg::at_least_one(cfg.presence_sample_us));
			PH_RST_TAIL: cur_len = owm_pkg::cap_len(cfg.reset_tail_us);
			PH_WR_LOW:   cur_len = owm_pkg::cap_len(owm_pkg::at_least_one(
			                 wbit ? cfg.write1_low_us : cfg.write0_low_us));
			PH_WR_TAIL:  cur_len = owm_pkg::cap_len(wbit ? cfg.write1_tail_us : '0);
			PH_RD_LOW:   cur_len = owm_pkg::COUNT_WIDTH'(1);
			PH_RD_WAIT:  cur_len = owm_pkg::cap_len(owm_pkg::at_least_one(cfg.read_sample_us));
			PH_RD_TAIL:  cur_len = owm_pkg::cap_len(cfg.read_tail_us);
			default:     cur_len = owm_pkg::COUNT_WIDTH'(1);
		endcase
	end

	// Next state for one tick
	always_comb begin
		phase_n  = phase_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		act_n    = act_q;
		shift_n  = shift_q;
		pres_n   = pres_q;
		crc_n    = crc_q;
		hold_n   = hold_q;
		done_n   = 1'b0;
		tail_end = 1'b0;
		fin      = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (cmd_valid) begin
				case (opcode)
					owm_pkg::OP_RESET: begin
						act_n   = opcode;
						bit_n   = '0;
						phase_n = PH_RST_LOW;
						tick_n  = '0;
					end
					owm_pkg::OP_WBIT, owm_pkg::OP_WBYTE: begin
						act_n   = opcode;
						bit_n   = '0;
						shift_n = (opcode == owm_pkg::OP_WBIT) ? {7'b0, write_data[0]} :
						          write_data;
						phase_n = PH_WR_LOW;
						tick_n  = '0;
					end
					owm_pkg::OP_RBIT, owm_pkg::OP_RBYTE: begin
						act_n   = opcode;
						bit_n   = '0;
						shift_n = '0;
						phase_n = PH_RD_LOW;
						tick_n  = '0;
					end
					owm_pkg::OP_CLRCRC: begin
						crc_n  = '0;
						done_n = 1'b1;
					end
					default: ;
				endcase
			end
		end else begin
			tick_n = tick_inc;
			if (tick_inc >= cur_len) begin
				tick_n = '0;
				// End of the current phase; a zero-length tail ends at once
				case (phase_q)
					PH_RST_LOW: phase_n = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pres_n  = ~line_level;
						phase_n = PH_RST_TAIL;
						fin     = (cfg.reset_tail_us == '0);
					end
					PH_RST_TAIL: fin = 1'b1;
					PH_WR_LOW: begin
						phase_n  = PH_WR_TAIL;
						tail_end = !wbit || (cfg.write1_tail_us == '0);
					end
					PH_WR_TAIL: tail_end = 1'b1;
					PH_RD_LOW: phase_n = PH_RD_WAIT;
					PH_RD_WAIT: begin
						shift_n[bit_q] = shift_q[bit_q] | line_level;
						phase_n        = PH_RD_TAIL;
						tail_end       = (cfg.read_tail_us == '0);
					end
					PH_RD_TAIL: tail_end = 1'b1;
					default: fin = 1'b1;
				endcase
				// After a tail: next bit of a byte, or done
				if (tail_end) begin
					if ((act_q == owm_pkg::OP_WBYTE || act_q == owm_pkg::OP_RBYTE) &&
					    bit_q != 3'd7) begin
						bit_n   = bit_q + 3'd1;
						phase_n = rd_family ? PH_RD_LOW : PH_WR_LOW;
					end else begin
						fin = 1'b1;
					end
				end
				if (fin) begin
					phase_n = PH_IDLE;
					done_n  = 1'b1;
					if (act_q == owm_pkg::OP_RBIT) begin
						hold_n = {7'b0, shift_n[0]};
					end else if (act_q == owm_pkg::OP_RBYTE) begin
						hold_n = shift_n;
						crc_n  = owm_pkg::crc8_step(crc_q, shift_n);
					end
				end
			end
		end
	end

	// State registers advance once per tick beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			act_q   <= owm_pkg::OP_NONE;
			shift_q <= '0;
			pres_q  <= 1'b0;
			crc_q   <= '0;
			hold_q  <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			act_q   <= act_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
			crc_q   <= crc_n;
			hold_q  <= hold_n;
		end
	end

	// Result shows the state after this tick
	always_comb begin
		res.drive_low = (phase_n == PH_RST_LOW) || (phase_n == PH_WR_LOW) ||
		                (phase_n == PH_RD_LOW);
		res.busy      = (phase_n != PH_IDLE);
		res.done      = done_n;
		res.presence  = pres_n;
		res.read_data = hold_n;
		res.crc       = crc_n;
	end

`ifndef SYNTH
	// Completion always returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !res.busy)
		else $error("done with block still busy");

	// Counter stays inside the running phase
	a_tick_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (tick_q < cur_len))
		else $error("tick count ran past phase length");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/owm_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire owm_pkg::res_t push_data,
	output logic               room,
	output logic               out_valid,
	input  wire logic          out_stall,
	output owm_pkg::res_t      out_data
);

	owm_pkg::res_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem_q[rd_q];

	// Result entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result beat pushed into full buffer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && ((cnt_q == 2'd0) == (wr_q == rd_q) || cnt_q == 2'd2))
		else $error("buffer count and pointers disagree");
`endif

endmodule

`default_nettype wire
